[hw/rtl/dpp_pkg.sv]
// Package for the derivation path parser: character codes, status codes,
// parser state and per-item result types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpp_pkg;

	localparam int unsigned MAX_DEPTH = 16;

	localparam logic [7:0] CH_M_LO  = 8'h6D; // 'm'
	localparam logic [7:0] CH_M_UP  = 8'h4D; // 'M'
	localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
	localparam logic [7:0] CH_APOS  = 8'h27; // apostrophe
	localparam logic [7:0] CH_H_LO  = 8'h68; // 'h'
	localparam logic [7:0] CH_H_UP  = 8'h48; // 'H'
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic [7:0] BIP44_HARD_LEVELS = 8'd3;
	localparam logic [7:0] BIP44_CHANGE_LVL  = 8'd3;
	localparam logic [7:0] BIP44_INDEX_LVL   = 8'd4;
	localparam logic [7:0] DEPTH_SAT         = 8'd255;

	localparam logic action_char = 1'b0;
	localparam logic action_end  = 1'b1;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic        first_char_seen;
		logic [30:0] segment_value;
		logic        segment_overflow;
		logic        segment_has_digit;
		logic        segment_marked;
		logic        segment_malformed;
		status_t     error_code;
		logic [7:0]  component_count;
		logic        bip44_violation;
	} dpp_state_t;

	typedef struct packed {
		logic        component_ready;
		logic [31:0] component;
		logic        path_done;
		logic [1:0]  status;
		logic [7:0]  depth;
		logic        bip44_ok;
	} dpp_result_t;

	localparam dpp_state_t STATE_RESET = '{
		first_char_seen:   1'b0,
		segment_value:     31'd0,
		segment_overflow:  1'b0,
		segment_has_digit: 1'b0,
		segment_marked:    1'b0,
		segment_malformed: 1'b0,
		error_code:        STATUS_OK,
		component_count:   8'd0,
		bip44_violation:   1'b0
	};

endpackage

`default_nettype wire

[hw/rtl/dpp_if.sv]
// Request and response channel interfaces of the derivation path parser.
// Depends on nothing; payload widths follow the item fields.
`timescale 1ns / 1ps
`default_nettype none

interface dpp_req_if;
	logic       valid;
	logic       ready;
	logic       action;
	logic [7:0] ch;
	modport source (output valid, output action, output ch, input ready);
	modport sink (input valid, input action, input ch, output ready);
endinterface

interface dpp_rsp_if;
	logic        valid;
	logic        ready;
	logic        component_ready;
	logic [31:0] component;
	logic        path_done;
	logic [1:0]  status;
	logic [7:0]  depth;
	logic        bip44_ok;
	modport source (output valid, output component_ready, output component,
		output path_done, output status, output depth, output bip44_ok, input ready);
	modport sink (input valid, input component_ready, input component,
		input path_done, input status, input depth, input bip44_ok, output ready);
endinterface

`default_nettype wire

[hw/rtl/dpp_step.sv]
// Per-character update of the path parser: next state and result for one request.
// Depends on dpp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpp_step (
	input  dpp_pkg::dpp_state_t  st,
	input  logic                 action,
	input  logic [7:0]           ch,
	output dpp_pkg::dpp_state_t  nxt,
	output dpp_pkg::dpp_result_t res
);
	import dpp_pkg::*;

	logic        skip_m;
	logic        is_digit;
	logic        is_marker;
	logic        close_seg;
	logic        seg_empty;
	logic [3:0]  digit;
	logic [34:0] prod;
	dpp_state_t  n;

	assign is_digit  = (ch >= CH_0) && (ch <= CH_9);
	assign is_marker = (ch == CH_APOS) || (ch == CH_H_LO) || (ch == CH_H_UP);
	assign skip_m    = !st.first_char_seen && ((ch == CH_M_LO) || (ch == CH_M_UP));
	assign digit     = 4'(ch - CH_0);
	// value * 10 + digit as (v << 3) + (v << 1) + d
	assign prod = {1'b0, st.segment_value, 3'b000} + {3'b000, st.segment_value, 1'b0}
		+ {31'd0, digit};
	assign seg_empty = !st.segment_has_digit && !st.segment_marked && !st.segment_malformed;

	always_comb begin
		n         = st;
		close_seg = 1'b0;
		res       = '0;

		if (action == action_char) begin
			if (st.error_code == STATUS_OK) begin
				n.first_char_seen = 1'b1;
				if (!skip_m) begin
					if (ch == CH_SLASH) begin
						close_seg = 1'b1;
					end else if (is_digit) begin
						if (st.segment_marked) begin
							n.segment_malformed = 1'b1;
						end else begin
							n.segment_has_digit = 1'b1;
							if (!st.segment_overflow) begin
								if (prod[34:31] != 4'd0)
									n.segment_overflow = 1'b1;
								else
									n.segment_value = prod[30:0];
							end
						end
					end else if (is_marker) begin
						if (st.segment_marked)
							n.segment_malformed = 1'b1;
						else
							n.segment_marked = 1'b1;
					end else begin
						n.segment_malformed = 1'b1;
					end
				end
			end
		end else begin
			close_seg = 1'b1;
		end

		// finish the open segment
		if (close_seg) begin
			if (st.error_code == STATUS_OK && !seg_empty) begin
				if (st.segment_malformed || !st.segment_has_digit) begin
					n.error_code = STATUS_INVALID;
				end else if (st.segment_overflow) begin
					n.error_code = STATUS_RANGE;
				end else begin
					if (st.component_count < BIP44_HARD_LEVELS && !st.segment_marked)
						n.bip44_violation = 1'b1;
					if (st.component_count == BIP44_CHANGE_LVL
						&& (st.segment_marked || st.segment_value > 31'd1))
						n.bip44_violation = 1'b1;
					if (st.component_count == BIP44_INDEX_LVL && st.segment_marked)
						n.bip44_violation = 1'b1;
					if (st.component_count != DEPTH_SAT)
						n.component_count = st.component_count + 8'd1;
					res.component_ready = 1'b1;
					res.component       = {st.segment_marked, st.segment_value};
				end
			end
			n.segment_value     = '0;
			n.segment_overflow  = 1'b0;
			n.segment_has_digit = 1'b0;
			n.segment_marked    = 1'b0;
			n.segment_malformed = 1'b0;
		end

		if (action == action_end) begin
			res.path_done = 1'b1;
			if (n.error_code == STATUS_OK && !st.first_char_seen)
				n.error_code = STATUS_INVALID;
			if (n.error_code == STATUS_OK && n.component_count > 8'(MAX_DEPTH))
				n.error_code = STATUS_INVALID;
			res.bip44_ok = (n.error_code == STATUS_OK)
				&& ((n.component_count < BIP44_HARD_LEVELS) || !n.bip44_violation);
		end

		res.status = n.error_code;
		res.depth  = n.component_count;

		nxt = (action == action_end) ? STATE_RESET : n;
	end

endmodule

`default_nettype wire

[hw/rtl/derivation_path_parser.sv]
// Top level of the derivation path parser: input register, step logic, result register.
// Depends on dpp_pkg, dpp_if (dpp_req_if, dpp_rsp_if) and dpp_step.
`timescale 1ns / 1ps
`default_nettype none

// The parser reads a derivation path text (for example m/44'/0'/0'/0/5) one
// character per request and returns exactly one result per request. A request
// with action 0 carries one character; action 1 ends the path, reports status,
// depth and the BIP-44 shape check, and clears all parser state. The request
// sits in the input register while the step logic works out the next parser
// state and the result; both load, into the parser state and the result
// register, when the result register is free or its result is taken. A new
// request is accepted every cycle while results are taken; a stalled result
// holds the result register, and the input register still takes one more
// request behind it. Sustained rate: one request per cycle while results are
// taken, set by the combinational state update (a multiply-by-ten accumulate
// on a 31-bit value).
module derivation_path_parser (
	input  logic  clk,
	input  logic  arst_n,
	dpp_req_if.sink   req,
	dpp_rsp_if.source rsp
);
	import dpp_pkg::*;

	// input register
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  ch_s1;

	// parser state and result register
	dpp_state_t  state_q;
	dpp_state_t  state_nxt;
	dpp_result_t step_res;
	dpp_result_t rsp_q;
	logic        rsp_valid_q;

	logic        adv_s1;

	// move the held request into the result register when that register is free
	assign adv_s1    = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			ch_s1     <= req.ch;
		end
	end

	dpp_step u_step (
		.st     (state_q),
		.action (action_s1),
		.ch     (ch_s1),
		.nxt    (state_nxt),
		.res    (step_res)
	);

	// advance parser state only when the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			rsp_q <= step_res;
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.component_ready = rsp_q.component_ready;
	assign rsp.component       = rsp_q.component;
	assign rsp.path_done       = rsp_q.path_done;
	assign rsp.status          = rsp_q.status;
	assign rsp.depth           = rsp_q.depth;
	assign rsp.bip44_ok        = rsp_q.bip44_ok;

endmodule

`default_nettype wire

[hw/rtl/dpp_checker.sv]
// Port-level checks on the derivation path parser results, bound to the top level.
// Depends on dpp_pkg and derivation_path_parser.
`timescale 1ns / 1ps
`default_nettype none

module dpp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        component_ready,
	input logic [31:0] component,
	input logic        path_done,
	input logic [1:0]  status,
	input logic        bip44_ok
);
	import dpp_pkg::*;

	// a component is only reported while no error is pending on a character request
	a_comp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && component_ready && !path_done |-> status == STATUS_OK)
		else $error("component reported with an error status");

	a_comp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !component_ready |-> component == 32'd0)
		else $error("component not zero without component_ready");

	a_bip44: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && bip44_ok |-> path_done && status == STATUS_OK)
		else $error("bip44_ok outside a clean end of path");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(component) && $stable(status)
			&& $stable(path_done))
		else $error("stalled result changed");

endmodule

bind derivation_path_parser dpp_checker u_dpp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.component_ready (rsp.component_ready),
	.component       (rsp.component),
	.path_done       (rsp.path_done),
	.status          (rsp.status),
	.bip44_ok        (rsp.bip44_ok)
);

`default_nettype wire
